// ----- hw/rtl/lmb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_pkg: shared definitions for the 3x3 local-mean binariser
// Default sizes, the configuration register width, command codes and the
// flag bundle that travels with each result through the job queue.
// ----------------------------------------------------------------------------
package lmb_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_DIM_DEF    = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Width of the image dimension register and its value after reset.
    localparam int CFG_W     = 11;
    localparam int DIM_RESET = 1024;

    // Entries in the job queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 4;

    // Input command codes.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Markers that accompany one result.
    typedef struct packed {
        logic eor;
        logic eof;
    } t_flags;

endpackage

// ----- hw/rtl/lmb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_front: transaction intake, line stores and window builder
// Accepts pixel and drain transactions, keeps the raster counters, reads and
// updates the two line stores, maintains the 3x3 window and hands up to two
// window snapshots per transaction to the job queue.
// ----------------------------------------------------------------------------
module lmb_front #(
    parameter int MAX_DIM    = lmb_pkg::MAX_DIM_DEF,
    parameter int PIXEL_BITS = lmb_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lmb_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                        i_valid,
    input  logic                        i_cmd,
    input  logic [PIXEL_BITS-1:0]       i_pixel,
    output logic                        o_stall,
    input  logic                        i_room,
    output logic [1:0]                  o_push_cnt,
    output logic [9*PIXEL_BITS-1:0]     o_win0,
    output lmb_pkg::t_flags             o_flags0,
    output logic [9*PIXEL_BITS-1:0]     o_win1,
    output lmb_pkg::t_flags             o_flags1
);
    import lmb_pkg::*;

    localparam int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int CW      = (CFG_W > DW) ? CFG_W : DW;
    localparam int DIM_RST = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DIM - 1);

    // Configuration and raster state.
    logic [DW-1:0]          r_dim;
    logic [DW-1:0]          n_dim;
    logic [AW-1:0]          r_in_col;
    logic [AW-1:0]          r_in_row;
    logic [AW-1:0]          r_out_col;
    logic                   r_pending;

    // Stage one: the transaction whose store data is being read.
    logic                   r_s1_valid;
    logic                   r_s1_drain;
    logic                   r_s1_row0;
    logic                   r_s1_col0;
    logic                   r_s1_emit_a;
    logic                   r_s1_emit_b;
    logic                   r_s1_last;
    logic                   r_s1_first;
    logic [AW-1:0]          r_s1_addr;
    logic [PIXEL_BITS-1:0]  r_s1_pix;

    // Line stores, their registered read data and a copy of column zero.
    logic [PIXEL_BITS-1:0]  r_mem_up  [MAX_DIM];
    logic [PIXEL_BITS-1:0]  r_mem_mid [MAX_DIM];
    logic [PIXEL_BITS-1:0]  r_up_rd;
    logic [PIXEL_BITS-1:0]  r_mid_rd;
    logic [PIXEL_BITS-1:0]  r_c0_up;
    logic [PIXEL_BITS-1:0]  r_c0_mid;

    // Window, indexed as three times the column plus the row.
    logic [PIXEL_BITS-1:0]  r_win   [9];
    logic [PIXEL_BITS-1:0]  n_win   [9];
    logic [PIXEL_BITS-1:0]  win_b   [9];
    logic [PIXEL_BITS-1:0]  col_new [3];
    logic [PIXEL_BITS-1:0]  dcol    [3];
    logic [PIXEL_BITS-1:0]  c0col   [3];
    logic [9*PIXEL_BITS-1:0] pk_a;
    logic [9*PIXEL_BITS-1:0] pk_b;

    logic                   acc;
    logic                   s1_fire;
    logic                   is_drain;
    logic                   in_last_col;
    logic                   in_last_row;
    logic                   out_last;
    logic [AW-1:0]          rd_addr;
    logic                   mem_wr;
    logic                   fwd;
    logic [PIXEL_BITS-1:0]  up_w;
    logic [CW-1:0]          cfg_ext;

    // Handshake: stage one completes once the queue can take two jobs.
    assign s1_fire = r_s1_valid && i_room;
    assign o_stall = r_s1_valid && !i_room;
    assign acc     = i_valid && !o_stall;
    assign is_drain = (i_cmd == CMD_DRAIN);

    // Position tests against the current image size.
    assign in_last_col = (DW'(r_in_col) + DW'(1)) >= r_dim;
    assign in_last_row = (DW'(r_in_row) + DW'(1)) >= r_dim;
    assign out_last    = (DW'(r_out_col) + DW'(1)) >= r_dim;

    // A drain reads the column right of the result it produces.
    assign rd_addr = is_drain ? ((r_out_col == LAST_ADDR) ? r_out_col
                                                          : r_out_col + AW'(1))
                              : r_in_col;

    // The image size is held clamped to the supported range.
    assign cfg_ext = CW'(i_cfg_wr_data);
    always_comb begin
        if (cfg_ext == '0) begin
            n_dim = DW'(1);
        end else if (cfg_ext > CW'(MAX_DIM)) begin
            n_dim = DW'(MAX_DIM);
        end else begin
            n_dim = DW'(cfg_ext);
        end
    end

    // Configuration register and raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim     <= DW'(DIM_RST);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_pending <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dim <= n_dim;
            end
            if (acc) begin
                if (!is_drain) begin
                    r_pending <= in_last_col && in_last_row;
                    if (in_last_col) begin
                        r_in_col <= '0;
                        if (in_last_row) begin
                            r_in_row  <= '0;
                            r_out_col <= '0;
                        end else begin
                            r_in_row <= r_in_row + AW'(1);
                        end
                    end else begin
                        r_in_col <= r_in_col + AW'(1);
                    end
                end else if (r_pending) begin
                    if (out_last) begin
                        r_pending <= 1'b0;
                        r_out_col <= '0;
                    end else begin
                        r_out_col <= r_out_col + AW'(1);
                    end
                end
            end
        end
    end

    // Stage one occupancy; a drain with nothing pending is dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= !is_drain || r_pending;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage one payload, classified at intake.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_drain  <= is_drain;
            r_s1_row0   <= (r_in_row == '0);
            r_s1_col0   <= (r_in_col == '0);
            r_s1_emit_a <= (r_in_row != '0) && (r_in_col != '0);
            r_s1_emit_b <= (r_in_row != '0) && in_last_col;
            r_s1_last   <= out_last;
            r_s1_first  <= (r_out_col == '0);
            r_s1_addr   <= rd_addr;
            r_s1_pix    <= i_pixel;
        end
    end

    // Line store update: the upper store inherits the old middle entry.
    assign mem_wr = s1_fire && !r_s1_drain;
    assign up_w   = r_s1_row0 ? r_s1_pix : r_mid_rd;
    assign fwd    = mem_wr && (r_s1_addr == rd_addr);

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem_up[r_s1_addr]  <= up_w;
            r_mem_mid[r_s1_addr] <= r_s1_pix;
        end
        if (acc) begin
            if (fwd) begin
                r_up_rd  <= up_w;
                r_mid_rd <= r_s1_pix;
            end else begin
                r_up_rd  <= r_mem_up[rd_addr];
                r_mid_rd <= r_mem_mid[rd_addr];
            end
        end
    end

    // Column zero is kept aside so the first drain needs only one read.
    always_ff @(posedge i_clk) begin
        if (mem_wr && r_s1_col0) begin
            r_c0_up  <= up_w;
            r_c0_mid <= r_s1_pix;
        end
    end

    // Next window and its right-replicated copy for the end of a row.
    always_comb begin
        col_new[0] = r_s1_row0 ? r_s1_pix : r_up_rd;
        col_new[1] = r_s1_row0 ? r_s1_pix : r_mid_rd;
        col_new[2] = r_s1_pix;
        dcol[0]    = r_up_rd;
        dcol[1]    = r_mid_rd;
        dcol[2]    = r_mid_rd;
        c0col[0]   = r_c0_up;
        c0col[1]   = r_c0_mid;
        c0col[2]   = r_c0_mid;
        for (int j = 0; j < 3; j++) begin
            if (!r_s1_drain) begin
                if (r_s1_col0) begin
                    n_win[j]     = col_new[j];
                    n_win[3 + j] = col_new[j];
                    n_win[6 + j] = col_new[j];
                end else begin
                    n_win[j]     = r_win[3 + j];
                    n_win[3 + j] = r_win[6 + j];
                    n_win[6 + j] = col_new[j];
                end
            end else begin
                if (r_s1_first) begin
                    n_win[j]     = c0col[j];
                    n_win[3 + j] = c0col[j];
                    n_win[6 + j] = r_s1_last ? c0col[j] : dcol[j];
                end else begin
                    n_win[j]     = r_win[3 + j];
                    n_win[3 + j] = r_win[6 + j];
                    n_win[6 + j] = r_s1_last ? r_win[6 + j] : dcol[j];
                end
            end
            win_b[j]     = n_win[3 + j];
            win_b[3 + j] = n_win[6 + j];
            win_b[6 + j] = n_win[6 + j];
        end
        for (int i = 0; i < 9; i++) begin
            pk_a[i*PIXEL_BITS +: PIXEL_BITS] = n_win[i];
            pk_b[i*PIXEL_BITS +: PIXEL_BITS] = win_b[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_win <= n_win;
        end
    end

    // Jobs towards the queue.
    always_comb begin
        if (!s1_fire) begin
            o_push_cnt = 2'd0;
        end else if (r_s1_drain) begin
            o_push_cnt = 2'd1;
        end else begin
            o_push_cnt = 2'(r_s1_emit_a) + 2'(r_s1_emit_b);
        end
        if (r_s1_drain) begin
            o_win0   = pk_a;
            o_flags0 = t_flags'{eor: r_s1_last, eof: r_s1_last};
        end else if (r_s1_emit_a) begin
            o_win0   = pk_a;
            o_flags0 = t_flags'{eor: 1'b0, eof: 1'b0};
        end else begin
            o_win0   = pk_b;
            o_flags0 = t_flags'{eor: 1'b1, eof: 1'b0};
        end
        o_win1   = pk_b;
        o_flags1 = t_flags'{eor: 1'b1, eof: 1'b0};
    end

endmodule

// ----- hw/rtl/lmb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_queue: job queue between front and back
// A short FIFO of window snapshots that takes up to two jobs and gives one
// job per cycle when popped, so that intake and result delivery stall apart.
// ----------------------------------------------------------------------------
module lmb_queue #(
    parameter int PIXEL_BITS = lmb_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_push_cnt,
    input  logic [9*PIXEL_BITS-1:0]     i_win0,
    input  lmb_pkg::t_flags             i_flags0,
    input  logic [9*PIXEL_BITS-1:0]     i_win1,
    input  lmb_pkg::t_flags             i_flags1,
    output logic                        o_room,
    output logic                        o_nempty,
    input  logic                        i_pop,
    output logic [9*PIXEL_BITS-1:0]     o_win,
    output lmb_pkg::t_flags             o_flags
);
    import lmb_pkg::*;

    localparam int WIN_W = 9 * PIXEL_BITS;
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);

    logic [WIN_W-1:0]   r_q_win   [QUEUE_DEPTH];
    t_flags             r_q_flags [QUEUE_DEPTH];
    logic [PW-1:0]      r_wp;
    logic [PW-1:0]      r_rp;
    logic [CNTW-1:0]    r_cnt;
    logic [PW-1:0]      wp1;

    assign wp1 = r_wp + PW'(1);

    // Room for a full pair of jobs is what the front waits for.
    assign o_room   = r_cnt <= CNTW'(QUEUE_DEPTH - 2);
    assign o_nempty = r_cnt != '0;
    assign o_win    = r_q_win[r_rp];
    assign o_flags  = r_q_flags[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push_cnt);
            r_rp  <= r_rp + PW'(i_pop);
            r_cnt <= r_cnt + CNTW'(i_push_cnt) - CNTW'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_q_win[r_wp]   <= i_win0;
            r_q_flags[r_wp] <= i_flags0;
        end
        if (i_push_cnt == 2'd2) begin
            r_q_win[wp1]   <= i_win1;
            r_q_flags[wp1] <= i_flags1;
        end
    end

endmodule

// ----- hw/rtl/lmb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_back: threshold datapath and result register
// Pops one window per cycle unless the output stalls, forms the column sums
// and nine times the centre; the output stage compares the total against it.
// ----------------------------------------------------------------------------
module lmb_back #(
    parameter int PIXEL_BITS = lmb_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_nempty,
    output logic                        o_pop,
    input  logic [9*PIXEL_BITS-1:0]     i_win,
    input  lmb_pkg::t_flags             i_flags,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_bit_value,
    output logic                        o_end_of_row,
    output logic                        o_end_of_frame
);
    import lmb_pkg::*;

    localparam int SW = PIXEL_BITS + 4;

    logic                       r_av;
    logic [PIXEL_BITS+1:0]      r_colsum [3];
    logic [SW-1:0]              r_c9;
    t_flags                     r_a_flags;
    logic                       r_ov;
    logic                       r_bit;
    t_flags                     r_o_flags;
    logic                       out_free;
    logic                       a_free;
    logic [SW-1:0]              total;
    logic [PIXEL_BITS-1:0]      centre;

    // Pipeline flow control.
    assign out_free = !r_ov || !i_stall;
    assign a_free   = !r_av || out_free;
    assign o_pop    = i_nempty && a_free;

    assign centre = i_win[4*PIXEL_BITS +: PIXEL_BITS];
    assign total  = SW'(r_colsum[0]) + SW'(r_colsum[1]) + SW'(r_colsum[2]);

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (a_free) begin
                r_av <= o_pop;
            end
            if (out_free) begin
                r_ov <= r_av;
            end
        end
    end

    // First stage: column sums and nine times the centre pixel.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < 3; k++) begin
                r_colsum[k] <= (PIXEL_BITS+2)'(i_win[(3*k)*PIXEL_BITS +: PIXEL_BITS])
                             + (PIXEL_BITS+2)'(i_win[(3*k+1)*PIXEL_BITS +: PIXEL_BITS])
                             + (PIXEL_BITS+2)'(i_win[(3*k+2)*PIXEL_BITS +: PIXEL_BITS]);
            end
            r_c9      <= SW'({centre, 3'b000}) + SW'(centre);
            r_a_flags <= i_flags;
        end
    end

    // Output stage: a centre above the local mean gives a zero.
    always_ff @(posedge i_clk) begin
        if (out_free && r_av) begin
            r_bit     <= (r_c9 > total) ? 1'b0 : 1'b1;
            r_o_flags <= r_a_flags;
        end
    end

    assign o_valid        = r_ov;
    assign o_bit_value    = r_bit;
    assign o_end_of_row   = r_o_flags.eor;
    assign o_end_of_frame = r_o_flags.eof;

endmodule

// ----- hw/rtl/local_mean_binarize_3x3_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_mean_binarize_3x3_unit: 3x3 local-mean binariser, top level
// Streams a square image in raster order and gives one threshold bit per
// pixel, with replicate padding on every edge.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock unless intake stalls: a pixel, or
// a drain that releases one result of the bottom row after the last pixel of
// an image. Results for row r-1 leave while row r streams in, one result per
// clock while results are taken, through front stage one, the job queue, the
// first back stage and the output register; a row's last pixel yields two
// results and its first pixel none, so a short job queue evens this out and
// intake holds one pixel a clock as long as results are taken.
// Intake stalls only when the queue cannot take two more jobs. Two line
// stores of MAX_DIM entries each, written per pixel and read per transaction,
// hold the two previous rows; they start undefined and need no clearing pass,
// so the unit accepts transactions from the first cycle after reset.
// image_dim may be written between transactions; it is clamped to 1..MAX_DIM.
// ----------------------------------------------------------------------------
module local_mean_binarize_3x3_unit #(
    parameter int MAX_DIM    = lmb_pkg::MAX_DIM_DEF,
    parameter int PIXEL_BITS = lmb_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lmb_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [PIXEL_BITS-1:0]       i_pixel,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_bit_value,
    output logic                        o_end_of_row,
    output logic                        o_end_of_frame
);
    import lmb_pkg::*;

    logic                       room;
    logic [1:0]                 push_cnt;
    logic [9*PIXEL_BITS-1:0]    win0;
    logic [9*PIXEL_BITS-1:0]    win1;
    t_flags                     flags0;
    t_flags                     flags1;
    logic                       nempty;
    logic                       pop;
    logic [9*PIXEL_BITS-1:0]    q_win;
    t_flags                     q_flags;

    // Intake, line stores and window.
    lmb_front #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_in_valid),
        .i_cmd         (i_cmd),
        .i_pixel       (i_pixel),
        .o_stall       (o_in_stall),
        .i_room        (room),
        .o_push_cnt    (push_cnt),
        .o_win0        (win0),
        .o_flags0      (flags0),
        .o_win1        (win1),
        .o_flags1      (flags1)
    );

    // Job queue.
    lmb_queue #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_win0     (win0),
        .i_flags0   (flags0),
        .i_win1     (win1),
        .i_flags1   (flags1),
        .o_room     (room),
        .o_nempty   (nempty),
        .i_pop      (pop),
        .o_win      (q_win),
        .o_flags    (q_flags)
    );

    // Threshold datapath and result register.
    lmb_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nempty       (nempty),
        .o_pop          (pop),
        .i_win          (q_win),
        .i_flags        (q_flags),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_bit_value    (o_bit_value),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

// ----- hw/rtl/lmb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_checker: port-level checks for the local-mean binariser
// Watches the result channel and the intake stall of the top level over time.
// ----------------------------------------------------------------------------
module lmb_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic o_in_stall,
    input  logic o_out_valid,
    input  logic i_out_stall,
    input  logic o_bit_value,
    input  logic o_end_of_row,
    input  logic o_end_of_frame
);

    // A result held back by the receiver stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bit_value)
            && $stable(o_end_of_row) && $stable(o_end_of_frame))
        else $error("result changed while stalled");

    // The end of the image is always also the end of a row.
    a_eof_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_end_of_row)
        else $error("end of frame without end of row");

    // Straight after reset nothing is offered and intake is open.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("activity straight after reset");

endmodule

bind local_mean_binarize_3x3_unit lmb_checker u_lmb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_bit_value    (o_bit_value),
    .o_end_of_row   (o_end_of_row),
    .o_end_of_frame (o_end_of_frame)
);
